// ===== design/cfs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfs_pkg
// Types and constants shared by the command-to-CAN-frame segmenter.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int FRAME_PAYLOAD_DEF = 7;
  localparam int STORE_DEPTH       = 7;

  typedef enum logic [1:0] {
    PH_ADDR    = 2'd0,
    PH_FUNC    = 2'd1,
    PH_PAYLOAD = 2'd2
  } cfs_phase_t;

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last_byte;
  } cfs_in_t;

  typedef struct packed {
    logic [15:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  data_0;
    logic [7:0]  data_1;
    logic [7:0]  data_2;
    logic [7:0]  data_3;
    logic [7:0]  data_4;
    logic [7:0]  data_5;
    logic [7:0]  data_6;
    logic [7:0]  data_7;
    logic        final_frame;
    logic        status;
  } cfs_out_t;

endpackage
`default_nettype wire

// ===== design/cfs_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfs_skid
// Two-entry output stage: result register plus skid register, so the upstream
// side keeps taking requests while a frame waits, until the skid entry fills.
// ----------------------------------------------------------------------------
module cfs_skid
  import cfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire cfs_out_t push_data,
  output logic          room,
  output logic          frame_valid,
  input  wire logic     frame_ready,
  output cfs_out_t      frame
);

  logic     main_v;
  logic     skid_v;
  cfs_out_t main;
  cfs_out_t skid;

  assign room        = !skid_v;
  assign frame_valid = main_v;
  assign frame       = main;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (frame_ready || !main_v) begin
        if (skid_v) begin
          main_v <= 1'b1;
          skid_v <= 1'b0;
        end else begin
          main_v <= push;
        end
      end else if (push) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ready || !main_v) begin
      main <= skid_v ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> main_v) else $error("skid entry without result entry");

  a_held_frame: assert property (@(posedge clk) disable iff (rst)
    main_v && !frame_ready |=> main_v && $stable(main))
    else $error("stalled frame changed");

  a_held_skid: assert property (@(posedge clk) disable iff (rst)
    skid_v && !frame_ready |=> skid_v && $stable(skid))
    else $error("skid entry lost");

endmodule
`default_nettype wire

// ===== design/command_to_can_frame_segmenter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// command_to_can_frame_segmenter
// Splits a byte-wise motor command into CAN extended frames.
// ----------------------------------------------------------------------------
// Throughput: one command byte per cycle; the input stalls only when both
//   output entries are full.
// Output: a frame is decided when the request that completes it (buffer fill
//   or last byte) is accepted, then registered in the result or skid entry.
// Reset: clears phase, fill count, packet counter and output valids; the
//   payload buffer is not cleared, unused entries are masked by the fill count.
module command_to_can_frame_segmenter
  import cfs_pkg::*;
#(
  parameter int FRAME_PAYLOAD = FRAME_PAYLOAD_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  output logic          cmd_ready,
  input  wire cfs_in_t  cmd,
  output logic          frame_valid,
  input  wire logic     frame_ready,
  output cfs_out_t      frame
);

  localparam logic [2:0] FULL = 3'(FRAME_PAYLOAD);

  cfs_phase_t  phase;
  cfs_phase_t  phase_next;
  logic [7:0]  target_address;
  logic [7:0]  function_code;
  logic [2:0]  payload_fill;
  logic [7:0]  packet_counter;
  logic [7:0]  payload_store [STORE_DEPTH];

  logic        accept;
  logic        res_valid;
  cfs_out_t    res;
  logic [2:0]  fill_new;
  logic        emit;
  logic [7:0]  store_next [STORE_DEPTH];
  logic [7:0]  data [STORE_DEPTH];

  assign accept   = cmd_valid && cmd_ready;
  assign fill_new = payload_fill + 3'd1;
  assign emit     = (fill_new >= FULL) || cmd.last_byte;

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_next[k] = (3'(k) == payload_fill) ? cmd.cmd_byte : payload_store[k];
      data[k]       = (3'(k) < fill_new) ? store_next[k] : 8'd0;
    end
  end

  always_comb begin
    unique case (phase)
      PH_FUNC:    phase_next = cmd.last_byte ? PH_ADDR : PH_PAYLOAD;
      PH_PAYLOAD: phase_next = cmd.last_byte ? PH_ADDR : PH_PAYLOAD;
      default:    phase_next = cmd.last_byte ? PH_ADDR : PH_FUNC;
    endcase
  end

  always_comb begin
    res             = '0;
    res_valid       = 1'b0;
    res.final_frame = 1'b1;
    res.status      = 1'b1;
    unique case (phase)
      PH_PAYLOAD: begin
        res_valid       = emit;
        res.frame_id    = {target_address, packet_counter};
        res.frame_len   = {1'b0, fill_new} + 4'd1;
        res.data_0      = function_code;
        res.data_1      = data[0];
        res.data_2      = data[1];
        res.data_3      = data[2];
        res.data_4      = data[3];
        res.data_5      = data[4];
        res.data_6      = data[5];
        res.data_7      = data[6];
        res.final_frame = cmd.last_byte;
        res.status      = 1'b0;
      end
      default: res_valid = cmd.last_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ADDR;
      target_address <= 8'd0;
      function_code  <= 8'd0;
      payload_fill   <= 3'd0;
      packet_counter <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      unique case (phase)
        PH_FUNC: begin
          function_code  <= cmd.cmd_byte;
          payload_fill   <= 3'd0;
          packet_counter <= 8'd0;
        end
        PH_PAYLOAD: begin
          if (cmd.last_byte) begin
            payload_fill   <= 3'd0;
            packet_counter <= 8'd0;
          end else if (emit) begin
            payload_fill   <= 3'd0;
            packet_counter <= packet_counter + 8'd1;
          end else begin
            payload_fill   <= fill_new;
          end
        end
        default: begin
          target_address <= cmd.cmd_byte;
          payload_fill   <= 3'd0;
          packet_counter <= 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_PAYLOAD) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        payload_store[k] <= store_next[k];
      end
    end
  end

  cfs_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (accept && res_valid),
    .push_data   (res),
    .room        (cmd_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res.status |-> res.final_frame && res.frame_len == 4'd0)
    else $error("error result not cleared");

  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && !res.status |-> res.frame_len >= 4'd2)
    else $error("frame without payload");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    payload_fill < FULL) else $error("payload fill overran frame size");

  a_counter_start: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FUNC |-> packet_counter == 8'd0 && payload_fill == 3'd0)
    else $error("counters not cleared at command start");

endmodule
`default_nettype wire

// ===== test/command_to_can_frame_segmenter_tb.sv =====
// ----------------------------------------------------------------------------
// command_to_can_frame_segmenter_tb
// Drives byte-wise motor commands into the segmenter and predicts every CAN
// frame and short-command error it should emit. Covers short commands, frame
// boundaries, a long multi-frame command, output back-pressure and random
// traffic.
// ----------------------------------------------------------------------------
module command_to_can_frame_segmenter_tb;
  import cfs_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_ITEMS   = 400;
  localparam int DRAIN_CYCLES   = 10;

  logic     clk;
  logic     rst;
  logic     cmd_valid;
  logic     cmd_ready;
  cfs_in_t  cmd;
  logic     frame_valid;
  logic     frame_ready;
  cfs_out_t frame;

  // segmenter state as predicted
  cfs_phase_t seg_phase;
  logic [7:0] seg_addr;
  logic [7:0] seg_func;
  int         seg_fill;
  logic [7:0] seg_held [STORE_DEPTH];
  logic [7:0] seg_pkt;

  cfs_out_t pending_frames [$];

  int  error_count;
  int  requests_sent;
  int  commands_sent;
  int  frames_checked;
  int  short_errors_seen;
  int  cycle_count;
  int  hold_off_len;
  bit  no_idle;

  command_to_can_frame_segmenter uut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic end_command();
    seg_phase = PH_ADDR;
    seg_fill  = 0;
    seg_pkt   = 8'd0;
  endtask

  task automatic segment_byte(input logic [7:0] b, input logic lst);
    cfs_out_t   f;
    logic [7:0] d [STORE_DEPTH];
    f = '0;
    case (seg_phase)
      PH_FUNC: begin
        seg_func = b;
        if (lst) begin
          f.final_frame = 1'b1;
          f.status      = 1'b1;
          pending_frames.push_back(f);
          end_command();
        end else begin
          seg_phase = PH_PAYLOAD;
          seg_fill  = 0;
        end
      end
      PH_PAYLOAD: begin
        if (seg_fill < FRAME_PAYLOAD_DEF) begin
          seg_held[seg_fill] = b;
          seg_fill++;
        end
        if (seg_fill >= FRAME_PAYLOAD_DEF || lst) begin
          for (int k = 0; k < STORE_DEPTH; k++) begin
            d[k] = (k < seg_fill) ? seg_held[k] : 8'd0;
          end
          f.frame_id    = {seg_addr, seg_pkt};
          f.frame_len   = 4'(seg_fill + 1);
          f.data_0      = seg_func;
          f.data_1      = d[0];
          f.data_2      = d[1];
          f.data_3      = d[2];
          f.data_4      = d[3];
          f.data_5      = d[4];
          f.data_6      = d[5];
          f.data_7      = d[6];
          f.final_frame = lst;
          pending_frames.push_back(f);
          if (lst) begin
            end_command();
          end else begin
            seg_fill = 0;
            seg_pkt  = seg_pkt + 8'd1;
          end
        end
      end
      default: begin
        seg_addr = b;
        seg_fill = 0;
        seg_pkt  = 8'd0;
        if (lst) begin
          f.final_frame = 1'b1;
          f.status      = 1'b1;
          pending_frames.push_back(f);
          end_command();
        end else begin
          seg_phase = PH_FUNC;
        end
      end
    endcase
  endtask

  task automatic send_request(input logic [7:0] b, input logic lst);
    cfs_in_t req;
    int      gap;
    req.cmd_byte  = b;
    req.last_byte = lst;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= req;
    do @(posedge clk); while (!cmd_ready);
    segment_byte(b, lst);
    requests_sent++;
  endtask

  // plen < 0: address only, plen == 0: address and function code only
  task automatic send_command(input logic [7:0] addr, input logic [7:0] func,
                              input int plen, input bit fixed_fill,
                              input logic [7:0] fill_byte);
    commands_sent++;
    send_request(addr, plen < 0);
    if (plen < 0) return;
    send_request(func, plen == 0);
    for (int i = 1; i <= plen; i++) begin
      send_request(fixed_fill ? fill_byte : 8'($urandom), i == plen);
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : frame_check
    cfs_out_t want;
    if (!rst && frame_valid && frame_ready) begin
      if (pending_frames.size() == 0) begin
        $error("frame with nothing pending: id %0h len %0h", frame.frame_id,
               frame.frame_len);
        error_count++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (want.status) short_errors_seen++;
        check_field("frame_id",    want.frame_id,         frame.frame_id);
        check_field("frame_len",   16'(want.frame_len),   16'(frame.frame_len));
        check_field("data_0",      16'(want.data_0),      16'(frame.data_0));
        check_field("data_1",      16'(want.data_1),      16'(frame.data_1));
        check_field("data_2",      16'(want.data_2),      16'(frame.data_2));
        check_field("data_3",      16'(want.data_3),      16'(frame.data_3));
        check_field("data_4",      16'(want.data_4),      16'(frame.data_4));
        check_field("data_5",      16'(want.data_5),      16'(frame.data_5));
        check_field("data_6",      16'(want.data_6),      16'(frame.data_6));
        check_field("data_7",      16'(want.data_7),      16'(frame.data_7));
        check_field("final_frame", 16'(want.final_frame), 16'(frame.final_frame));
        check_field("status",      16'(want.status),      16'(frame.status));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    frame_ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        frame_ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        frame_ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        frame_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        frame_ready <= 1'b1;
      end else begin
        frame_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_short_commands();
    send_command(8'hFF, 8'h00, -1, 1'b1, 8'h00);
    send_command(8'h00, 8'hFF, 0, 1'b1, 8'h00);
  endtask

  task automatic test_frame_boundaries();
    send_command(8'hFF, 8'h00, 1, 1'b1, 8'hFF);
    // exactly one full buffer ending on the last byte: no empty frame after it
    send_command(8'h00, 8'hAA, 7, 1'b1, 8'h00);
    send_command(8'h5A, 8'h01, 8, 1'b0, 8'h00);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_off_len = 80;
    for (int i = 0; i < 5; i++) begin
      send_command(8'($urandom), 8'($urandom), 7, 1'b0, 8'h00);
    end
    send_command(8'($urandom), 8'($urandom), 30, 1'b0, 8'h00);
    wait_drained();
  endtask

  task automatic test_long_command();
    no_idle = 1'b1;
    send_command(8'h81, 8'h3C, 5 * FRAME_PAYLOAD_DEF + 5, 1'b0, 8'h00);
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int r;
    int plen;
    logic lst;
    start = requests_sent;
    while (requests_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // noise: last flag falls at random
        commands_sent++;
        do begin
          lst = ($urandom_range(0, 3) == 0);
          send_request(8'($urandom), lst);
        end while (!lst);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10)      plen = -1 + int'($urandom_range(0, 1));
        else if (r < 60) plen = $urandom_range(1, 8);
        else if (r < 85) plen = $urandom_range(9, 22);
        else             plen = $urandom_range(23, 45);
        send_command(8'($urandom), 8'($urandom), plen, 1'b0, 8'h00);
      end
      if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    cmd_valid         = 1'b0;
    cmd               = '0;
    error_count       = 0;
    requests_sent     = 0;
    commands_sent     = 0;
    frames_checked    = 0;
    short_errors_seen = 0;
    hold_off_len      = 0;
    no_idle           = 1'b0;
    end_command();
    seg_addr = 8'd0;
    seg_func = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_commands();
    test_frame_boundaries();
    test_backpressure();
    test_long_command();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d command bytes in %0d commands, incl. a long multi-frame one.",
             requests_sent, commands_sent);
    $display("Checked %0d frames, %0d of them short-command errors.",
             frames_checked, short_errors_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cfs_pkg.sv
design/cfs_skid.sv
design/command_to_can_frame_segmenter.sv
test/command_to_can_frame_segmenter_tb.sv
